// ===== hdl/tpia_pkg.sv =====
// Shared types and constants for the two-pool slot ID allocator.
// Used by the front classifier, the job queue, the back executor and the top level.
`timescale 1ns / 1ps

package tpia_pkg;

    localparam int ID_W     = 31;
    localparam int SLOT_W   = 8;
    localparam int GRP      = 16;   // bitmap search group width
    localparam int GRP_IW   = 4;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PW     = 1;
    localparam int Q_CW     = 2;

    typedef enum logic [2:0] {
        CMD_DEVID     = 3'd0,
        CMD_ALLOC_COM = 3'd1,
        CMD_ALLOC_SPC = 3'd2,
        CMD_FREE_COM  = 3'd3,
        CMD_FREE_SPC  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_UNREG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_DEVID = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_PICK = 2'd2,
        BK_EXEC = 2'd3
    } t_bk_state;

    typedef struct packed {
        t_op                op;
        logic               pool;       // 0 common, 1 special
        logic [SLOT_W-1:0]  index;      // zero-based slot for a release
        logic               range_err;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/two_pool_id_allocator.sv =====
// Two-pool slot ID allocator. Device ID and release commands pass from the job queue
// through IDLE and EXEC to the result beat, allocations through IDLE, SCAN and PICK
// (group scan then pick). The single back-end executor runs one job at a time; a
// 2-entry job queue lets the input run ahead of a stalled output.
// Reset (synchronous, active low): both pools all free, device count and start at 0.
`timescale 1ns / 1ps

module two_pool_id_allocator #(
    parameter int COMMON_SLOTS  = 32,
    parameter int SPECIAL_SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [2:0] command, [10:3] slot_id, rest zero
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // [30:0] result_id, [32:31] status, rest zero
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [tpia_pkg::ID_W-1:0]  r_start;
    logic                       w_push;
    logic                       w_pop;
    tpia_pkg::t_job             w_fjob;
    tpia_pkg::t_job             w_qjob;
    tpia_pkg::t_q_stat          w_q_stat;
    logic [tpia_pkg::ID_W-1:0]  w_rid;
    tpia_pkg::t_status          w_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {1'b0, r_start} : 32'd0;

    // register 0 only; low address bits are not decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_start <= pwdata[tpia_pkg::ID_W-1:0];
        end
    end

    tpia_front #(
        .COMMON_SLOTS  (COMMON_SLOTS),
        .SPECIAL_SLOTS (SPECIAL_SLOTS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_command     (s_axis_tdata[2:0]),
        .i_slot_id     (s_axis_tdata[10:3]),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_job         (w_fjob)
    );

    tpia_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_q_stat)
    );

    tpia_back #(
        .COMMON_SLOTS  (COMMON_SLOTS),
        .SPECIAL_SLOTS (SPECIAL_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_job       (w_qjob),
        .i_job_valid (!w_q_stat.empty),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result_id (w_rid),
        .o_status    (w_status)
    );

    assign m_axis_tdata = {7'd0, w_status, w_rid};

    a_no_result_after_reset : assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !m_axis_tvalid)
        else $error("result beat presented right after reset");

    a_error_has_zero_id : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status != tpia_pkg::ST_OK)) |-> (w_rid == '0))
        else $error("error status carries a nonzero id");

    a_queue_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> !w_q_stat.empty)
        else $error("job queue full and empty at once");

    a_pop_only_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job popped from empty queue");

endmodule

// ===== hdl/tpia_front.sv =====
// Front end: accepts command beats and turns each into a classified job.
// Depends on tpia_pkg.
`timescale 1ns / 1ps

module tpia_front #(
    parameter int COMMON_SLOTS  = 32,
    parameter int SPECIAL_SLOTS = 32
) (
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [2:0]                  i_command,
    input  logic [tpia_pkg::SLOT_W-1:0] i_slot_id,
    input  tpia_pkg::t_q_stat           i_q_stat,
    output logic                        o_push,
    output tpia_pkg::t_job              o_job
);

    logic w_range_c;
    logic w_range_s;

    assign s_axis_tready = !i_q_stat.full;
    assign o_push        = s_axis_tvalid && !i_q_stat.full;

    assign w_range_c = (i_slot_id == '0)
                    || (i_slot_id > tpia_pkg::SLOT_W'(COMMON_SLOTS));
    assign w_range_s = (i_slot_id == '0)
                    || (i_slot_id > tpia_pkg::SLOT_W'(SPECIAL_SLOTS));

    always_comb begin
        o_job.index     = i_slot_id - tpia_pkg::SLOT_W'(1);
        o_job.pool      = 1'b0;
        o_job.range_err = 1'b0;
        o_job.op        = tpia_pkg::OP_NOP;
        unique case (tpia_pkg::t_cmd'(i_command))
            tpia_pkg::CMD_DEVID: begin
                o_job.op = tpia_pkg::OP_DEVID;
            end
            tpia_pkg::CMD_ALLOC_COM: begin
                o_job.op = tpia_pkg::OP_ALLOC;
            end
            tpia_pkg::CMD_ALLOC_SPC: begin
                o_job.op   = tpia_pkg::OP_ALLOC;
                o_job.pool = 1'b1;
            end
            tpia_pkg::CMD_FREE_COM: begin
                o_job.op        = tpia_pkg::OP_FREE;
                o_job.range_err = w_range_c;
            end
            tpia_pkg::CMD_FREE_SPC: begin
                o_job.op        = tpia_pkg::OP_FREE;
                o_job.pool      = 1'b1;
                o_job.range_err = w_range_s;
            end
            default: begin
                o_job.op = tpia_pkg::OP_NOP;
            end
        endcase
    end

endmodule

// ===== hdl/tpia_queue.sv =====
// Short job queue between the front classifier and the back executor.
// Depends on tpia_pkg for the job type and depth.
`timescale 1ns / 1ps

module tpia_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tpia_pkg::t_job     i_job,
    input  logic               i_pop,
    output tpia_pkg::t_job     o_job,
    output tpia_pkg::t_q_stat  o_stat
);

    tpia_pkg::t_job             r_mem [tpia_pkg::Q_DEPTH];
    logic [tpia_pkg::Q_PW-1:0]  r_wptr;
    logic [tpia_pkg::Q_PW-1:0]  r_rptr;
    logic [tpia_pkg::Q_CW-1:0]  r_cnt;

    assign o_stat.full  = (r_cnt == tpia_pkg::Q_CW'(tpia_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + tpia_pkg::Q_PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + tpia_pkg::Q_PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + tpia_pkg::Q_CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - tpia_pkg::Q_CW'(1);
            end
        end
    end

endmodule

// ===== hdl/tpia_back.sv =====
// Back end: holds both free bitmaps and the device counter, runs one job at a
// time and drives the result register. Depends on tpia_pkg.
`timescale 1ns / 1ps

module tpia_back #(
    parameter int COMMON_SLOTS  = 32,
    parameter int SPECIAL_SLOTS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tpia_pkg::ID_W-1:0]   i_start,
    input  tpia_pkg::t_job              i_job,
    input  logic                        i_job_valid,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tpia_pkg::ID_W-1:0]   o_result_id,
    output tpia_pkg::t_status           o_status
);

    localparam int MAXS = (COMMON_SLOTS > SPECIAL_SLOTS) ? COMMON_SLOTS : SPECIAL_SLOTS;
    localparam int NG   = (MAXS + tpia_pkg::GRP - 1) / tpia_pkg::GRP;
    localparam int PW   = NG * tpia_pkg::GRP;
    localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int SW   = GIW + tpia_pkg::GRP_IW;

    tpia_pkg::t_bk_state            r_state, n_state;
    tpia_pkg::t_job                 r_job;
    logic [COMMON_SLOTS-1:0]        r_map_c;
    logic [SPECIAL_SLOTS-1:0]       r_map_s;
    logic [NG-1:0]                  r_grp_any;
    logic [tpia_pkg::ID_W-1:0]      r_count;
    logic                           r_valid;
    logic [tpia_pkg::ID_W-1:0]      r_rid;
    tpia_pkg::t_status              r_status;

    logic                           w_load;
    logic [PW-1:0]                  w_vec;
    logic                           w_found;
    logic [GIW-1:0]                 w_grp;
    logic [tpia_pkg::GRP-1:0]       w_bits;
    logic [tpia_pkg::GRP_IW-1:0]    w_bit;
    logic [SW-1:0]                  w_slot;
    logic                           w_fbit;

    assign o_valid     = r_valid;
    assign o_result_id = r_rid;
    assign o_status    = r_status;

    assign w_vec = r_job.pool ? PW'(r_map_s) : PW'(r_map_c);

    // lowest group with a free slot, then lowest free bit inside it
    always_comb begin
        w_found = 1'b0;
        w_grp   = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                w_found = 1'b1;
                w_grp   = GIW'(g);
            end
        end
        w_bits = '0;
        for (int g = 0; g < NG; g++) begin
            if (w_grp == GIW'(g)) begin
                w_bits = w_vec[g*tpia_pkg::GRP +: tpia_pkg::GRP];
            end
        end
        w_bit = '0;
        for (int b = tpia_pkg::GRP - 1; b >= 0; b--) begin
            if (w_bits[b]) begin
                w_bit = tpia_pkg::GRP_IW'(b);
            end
        end
        w_slot = {w_grp, w_bit};
    end

    // current bit of the slot named by a release
    always_comb begin
        w_fbit = 1'b0;
        if (r_job.pool) begin
            for (int i = 0; i < SPECIAL_SLOTS; i++) begin
                if (tpia_pkg::SLOT_W'(i) == r_job.index) begin
                    w_fbit = r_map_s[i];
                end
            end
        end else begin
            for (int i = 0; i < COMMON_SLOTS; i++) begin
                if (tpia_pkg::SLOT_W'(i) == r_job.index) begin
                    w_fbit = r_map_c[i];
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpia_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.op == tpia_pkg::OP_ALLOC) ? tpia_pkg::BK_SCAN
                                                               : tpia_pkg::BK_EXEC;
                end
            end
            tpia_pkg::BK_SCAN: begin
                n_state = tpia_pkg::BK_PICK;
            end
            tpia_pkg::BK_PICK, tpia_pkg::BK_EXEC: begin
                if (!r_valid || i_ready) begin
                    n_state = tpia_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = tpia_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            tpia_pkg::BK_IDLE: begin
                o_pop = i_job_valid;
            end
            tpia_pkg::BK_PICK, tpia_pkg::BK_EXEC: begin
                w_load = !r_valid || i_ready;
            end
            default: begin
                o_pop  = 1'b0;
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == tpia_pkg::BK_SCAN) begin
            for (int g = 0; g < NG; g++) begin
                r_grp_any[g] <= |w_vec[g*tpia_pkg::GRP +: tpia_pkg::GRP];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpia_pkg::BK_IDLE;
            r_valid  <= 1'b0;
            r_map_c  <= '1;
            r_map_s  <= '1;
            r_count  <= '0;
            r_rid    <= '0;
            r_status <= tpia_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_valid  <= 1'b1;
                r_rid    <= '0;
                r_status <= tpia_pkg::ST_OK;
                if (r_state == tpia_pkg::BK_PICK) begin
                    if (w_found) begin
                        r_rid <= tpia_pkg::ID_W'(w_slot) + tpia_pkg::ID_W'(1);
                        // claim the slot
                        if (r_job.pool) begin
                            for (int i = 0; i < SPECIAL_SLOTS; i++) begin
                                if (SW'(i) == w_slot) r_map_s[i] <= 1'b0;
                            end
                        end else begin
                            for (int i = 0; i < COMMON_SLOTS; i++) begin
                                if (SW'(i) == w_slot) r_map_c[i] <= 1'b0;
                            end
                        end
                    end else begin
                        r_status <= tpia_pkg::ST_FULL;
                    end
                end else begin
                    unique case (r_job.op)
                        tpia_pkg::OP_DEVID: begin
                            r_rid   <= i_start + r_count;
                            r_count <= r_count + tpia_pkg::ID_W'(1);
                        end
                        tpia_pkg::OP_FREE: begin
                            if (r_job.range_err) begin
                                r_status <= tpia_pkg::ST_RANGE;
                            end else if (w_fbit) begin
                                r_status <= tpia_pkg::ST_UNREG;
                            end else if (r_job.pool) begin
                                for (int i = 0; i < SPECIAL_SLOTS; i++) begin
                                    if (tpia_pkg::SLOT_W'(i) == r_job.index) r_map_s[i] <= 1'b1;
                                end
                            end else begin
                                for (int i = 0; i < COMMON_SLOTS; i++) begin
                                    if (tpia_pkg::SLOT_W'(i) == r_job.index) r_map_c[i] <= 1'b1;
                                end
                            end
                        end
                        default: begin
                            r_rid <= '0;
                        end
                    endcase
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for two_pool_id_allocator: random and directed commands on the
// input stream, results checked against an in-bench model of the pools and device counter.
// Depends on tpia_pkg and the two_pool_id_allocator RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int          COM_N      = 32;
    localparam int          SPC_N      = 32;
    localparam logic [2:0]  REG_START  = 3'd0;   // byte address of device_id_start
    localparam logic [2:0]  CMD_SPARE5 = 3'd5;
    localparam logic [2:0]  CMD_SPARE6 = 3'd6;
    localparam logic [2:0]  CMD_SPARE7 = 3'd7;
    localparam logic [30:0] ID_TOP     = 31'h7FFF_FFFF;
    localparam int          LONG_HOLD  = 300;
    localparam int          LIMIT      = 200000;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] slot;
    } t_cmd_beat;

    typedef struct packed {
        logic [30:0]        rid;
        tpia_pkg::t_status  st;
    } t_resp_beat;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    two_pool_id_allocator #(
        .COMMON_SLOTS  (COM_N),
        .SPECIAL_SLOTS (SPC_N)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),    // [2:0] command, [10:3] slot_id
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),    // [30:0] result_id, [32:31] status
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Model state of the allocator
    bit [31:0]   com_free  = '1;
    bit [31:0]   spc_free  = '1;
    bit [30:0]   dev_count = '0;
    bit [30:0]   dev_start = '0;

    t_cmd_beat   cmd_backlog[$];
    t_resp_beat  awaited_resp[$];
    int          fed = 0;
    int          taken = 0;
    int          errors = 0;
    int          cycles = 0;
    int          holds_asked = 0;
    int          holds_served = 0;

    function automatic t_resp_beat compute_response(input t_cmd_beat b);
        t_resp_beat r;
        bit [31:0]  map;
        int         n;
        bit         spc;
        r.rid = '0;
        r.st  = tpia_pkg::ST_OK;
        spc = (b.cmd == tpia_pkg::CMD_ALLOC_SPC) || (b.cmd == tpia_pkg::CMD_FREE_SPC);
        map = spc ? spc_free : com_free;
        n   = spc ? SPC_N : COM_N;
        case (b.cmd)
            tpia_pkg::CMD_DEVID: begin
                r.rid = dev_start + dev_count;
                dev_count = dev_count + 31'd1;
            end
            tpia_pkg::CMD_ALLOC_COM, tpia_pkg::CMD_ALLOC_SPC: begin
                r.st = tpia_pkg::ST_FULL;
                for (int i = 0; i < n; i++) begin
                    if (map[i]) begin
                        map[i] = 1'b0;
                        r.rid  = 31'(i + 1);
                        r.st   = tpia_pkg::ST_OK;
                        break;
                    end
                end
            end
            tpia_pkg::CMD_FREE_COM, tpia_pkg::CMD_FREE_SPC: begin
                if (b.slot == 8'd0 || b.slot > n)
                    r.st = tpia_pkg::ST_RANGE;
                else if (map[b.slot - 1])
                    r.st = tpia_pkg::ST_UNREG;
                else
                    map[b.slot - 1] = 1'b1;
            end
            default: ;
        endcase
        if (spc)
            spc_free = map;
        else
            com_free = map;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    // Sender: bursts of beats with random gaps in between
    int        burst_left = 0;
    int        gap_left = 0;
    t_cmd_beat cur_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_resp.push_back(compute_response(cur_beat));
                taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cur_beat = cmd_backlog.pop_front();
                    s_tdata <= {5'b0, cur_beat.slot, cur_beat.cmd};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern changes per window; a requested long hold-off overrides it
    int hold_left = 0;
    int win_left = 0;
    int rx_mode = 0;
    int rx_tick = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            win_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (win_left == 0) begin
                win_left = $urandom_range(8, 64);
                rx_mode = $urandom_range(0, 3);
            end
            win_left--;
            rx_tick++;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_tick % 3 == 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Result checker
    t_resp_beat want_resp;

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (awaited_resp.size() == 0) begin
                report("result beat with nothing awaited", m_tdata, 0);
            end else begin
                want_resp = awaited_resp.pop_front();
                if (m_tdata[30:0] != want_resp.rid)
                    report("result_id", m_tdata[30:0], want_resp.rid);
                if (m_tdata[32:31] != want_resp.st)
                    report("status", m_tdata[32:31], want_resp.st);
                if (m_tdata[39:33] != '0)
                    report("tdata padding", m_tdata[39:33], 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_cmd(input logic [2:0] cmd, input logic [7:0] slot);
        t_cmd_beat b;
        b.cmd = cmd;
        b.slot = slot;
        cmd_backlog.push_back(b);
        fed++;
    endtask

    task automatic write_start(input logic [30:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_START;
        pwdata <= {1'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dev_start = v;
        @(negedge i_clk);
    endtask

    // Hold until every command is accepted and answered, then let the pipeline drain
    task automatic wait_idle();
        while (fed != taken || awaited_resp.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic push_random(input int alloc_w);
        int          r;
        logic [7:0]  slot;
        logic [2:0]  cmd;
        r = $urandom_range(0, 99);
        slot = 8'($urandom_range(0, 255));
        if (r < 8) begin
            cmd = tpia_pkg::CMD_DEVID;
        end else if (r < 8 + alloc_w) begin
            cmd = $urandom_range(0, 1) ? tpia_pkg::CMD_ALLOC_SPC : tpia_pkg::CMD_ALLOC_COM;
        end else if (r < 95) begin
            cmd = $urandom_range(0, 1) ? tpia_pkg::CMD_FREE_SPC : tpia_pkg::CMD_FREE_COM;
            r = $urandom_range(0, 19);
            if (r == 0)
                slot = 8'd0;
            else if (r < 3)
                slot = 8'($urandom_range(33, 255));
            else
                slot = 8'($urandom_range(1, 32));
        end else begin
            cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
        end
        push_cmd(cmd, slot);
    endtask

    int alloc_w[7] = '{70, 15, 50, 70, 10, 40, 60};
    logic [30:0] start_v;

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every command, range edges, free of a free slot, unused codes
        push_cmd(tpia_pkg::CMD_DEVID, 8'hFF);
        push_cmd(tpia_pkg::CMD_DEVID, 8'h00);
        push_cmd(tpia_pkg::CMD_ALLOC_COM, 8'hFF);
        push_cmd(tpia_pkg::CMD_ALLOC_SPC, 8'h00);
        push_cmd(tpia_pkg::CMD_ALLOC_COM, 8'h00);
        push_cmd(tpia_pkg::CMD_FREE_COM, 8'd1);
        push_cmd(tpia_pkg::CMD_FREE_COM, 8'd1);
        push_cmd(tpia_pkg::CMD_FREE_COM, 8'd0);
        push_cmd(tpia_pkg::CMD_FREE_COM, 8'd33);
        push_cmd(tpia_pkg::CMD_FREE_COM, 8'd255);
        push_cmd(tpia_pkg::CMD_FREE_COM, 8'd32);
        push_cmd(tpia_pkg::CMD_FREE_SPC, 8'd1);
        push_cmd(tpia_pkg::CMD_FREE_SPC, 8'd0);
        push_cmd(tpia_pkg::CMD_FREE_SPC, 8'd33);
        push_cmd(tpia_pkg::CMD_FREE_SPC, 8'd32);
        push_cmd(CMD_SPARE5, 8'hAA);
        push_cmd(CMD_SPARE6, 8'h55);
        push_cmd(CMD_SPARE7, 8'hFF);
        wait_idle();

        // Device ID wrap past the top of the 31-bit range
        write_start(ID_TOP - 31'd1);
        repeat (4) push_cmd(tpia_pkg::CMD_DEVID, 8'h00);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       start_v = '0;
                1:       start_v = ID_TOP;
                3:       start_v = ID_TOP - 31'd3;
                default: start_v = 31'($urandom());
            endcase
            write_start(start_v);
            if (p == 2)
                holds_asked++;
            for (int k = 0; k < 100; k++) begin
                if (k < 34 && p == 0)
                    push_cmd(tpia_pkg::CMD_ALLOC_COM, 8'($urandom_range(0, 255)));
                else if (k < 34 && p == 3)
                    push_cmd(tpia_pkg::CMD_ALLOC_SPC, 8'($urandom_range(0, 255)));
                else
                    push_random(alloc_w[p]);
            end
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
